// File: rtl/hpc_pkg.sv
// Shared types and constants for the heating curve and PI pump controller.
// Holds the register map, the microcode word layout and the sample record.
// No dependencies.
package hpc_pkg;

	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned PC_W       = 4;

	// fixed control constants
	localparam logic signed [11:0] FROST_THRESHOLD = 12'sd48;
	localparam logic signed [31:0] VALVE_MIN       = 32'sd0;
	localparam logic signed [31:0] VALVE_MAX       = 32'sd25600;
	localparam logic [10:0]        PUMP_SP_MIN     = 11'd320;  // 20 degree
	localparam logic signed [12:0] PUMP_HYST       = 13'sd16;  // 1 degree

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SLOPE   = 3'd0,
		REG_OFFSET  = 3'd1,
		REG_SETBACK = 3'd2,
		REG_FMIN    = 3'd3,
		REG_FMAX    = 3'd4,
		REG_START   = 3'd5,
		REG_KP      = 3'd6,
		REG_KI      = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic        [9:0]  slope;
		logic signed [9:0]  offset;
		logic        [8:0]  setback;
		logic        [10:0] fmin;
		logic        [10:0] fmax;
		logic signed [10:0] start;
		logic        [15:0] kp;
		logic        [15:0] ki;
	} cfg_t;

	typedef struct packed {
		logic        [9:0]  room_setpoint;
		logic signed [10:0] outside_temp;
		logic signed [10:0] outside_avg;
		logic        [10:0] flow_temp;
		logic               reduced_mode;
		logic               party_active;
	} sample_t;

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_CURVE,
		MUL_Q0E,
		MUL_KPP
	} mul_sel_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_CURVE,
		OP_SETBACK,
		OP_CLAMP_LO,
		OP_CLAMP_HI,
		OP_ERR,
		OP_SAVE,
		OP_DIFF,
		OP_SCALE,
		OP_SAT
	} alu_op_t;

	typedef enum logic [0:0] {
		JC_NONE,
		JC_NO_SETBACK
	} jump_cond_t;

	typedef struct packed {
		mul_sel_t          mul_sel;
		alu_op_t           alu_op;
		jump_cond_t        jump_cond;
		logic [PC_W-1:0]   jump_target;
		logic              last;
	} cw_t;

	typedef struct packed {
		logic run;
		cw_t  cw;
	} ctrl_t;

	typedef struct packed {
		logic setback_en;
		logic out_free;
	} dp_status_t;

endpackage

// File: rtl/hpc_sample_if.sv
// Input channel of the controller: one sample per control period.
// No dependencies.
interface hpc_sample_if;
	logic               valid;
	logic               ready;
	logic        [9:0]  room_setpoint;
	logic signed [10:0] outside_temp;
	logic signed [10:0] outside_avg;
	logic        [10:0] flow_temp;
	logic               reduced_mode;
	logic               party_active;

	modport source (
		output valid, room_setpoint, outside_temp, outside_avg, flow_temp,
		       reduced_mode, party_active,
		input  ready
	);
	modport sink (
		input  valid, room_setpoint, outside_temp, outside_avg, flow_temp,
		       reduced_mode, party_active,
		output ready
	);
endinterface

// File: rtl/hpc_result_if.sv
// Output channel of the controller: one result per accepted sample.
// No dependencies.
interface hpc_result_if;
	logic        valid;
	logic        ready;
	logic [10:0] flow_setpoint;
	logic [14:0] valve_position;
	logic        pump_on;

	modport source (
		output valid, flow_setpoint, valve_position, pump_on,
		input  ready
	);
	modport sink (
		input  valid, flow_setpoint, valve_position, pump_on,
		output ready
	);
endinterface

// File: rtl/heating_curve_pi_pump_control_unit.sv
// Usage notes
// Weather-compensated heating curve with an incremental PI mixing valve
// controller and a hysteresis pump switch. One sample in, one result out.
// Channels: sample (valid/ready request with room setpoint, outside and
// averaged outside temperature, flow temperature and mode flags) and
// result (valid/ready request with flow setpoint, valve position, pump).
// Registers are written through write_en/reg_index/write_data; the user
// must write them only while idle, as the block does not enforce it.
// An 11-step microprogram (step 2, the setback, is skipped with no
// setback) runs one control word a cycle, unless the final step holds,
// through the shared 18x14 multiplier and the accumulator.
// A new request is taken as soon as the program ends, while the previous
// result may still be waiting.
// Stall: if the result is not taken, the program holds on its final step.
// Reset: registers return to their defaults, the valve accumulator, the
// previous error and the pump state clear, and no result is pending.
module heating_curve_pi_pump_control_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	hpc_sample_if.sink                     sample,
	hpc_result_if.source                   result,
	input  logic                           write_en,
	input  logic [hpc_pkg::CFG_IDX_W-1:0]  reg_index,
	input  logic [hpc_pkg::CFG_DATA_W-1:0] write_data
);
	import hpc_pkg::*;

	cfg_t       cfg;
	ctrl_t      ctrl;
	dp_status_t status;
	sample_t    smp;
	logic       in_ready;
	logic       accept;

	assign smp.room_setpoint = sample.room_setpoint;
	assign smp.outside_temp  = sample.outside_temp;
	assign smp.outside_avg   = sample.outside_avg;
	assign smp.flow_temp     = sample.flow_temp;
	assign smp.reduced_mode  = sample.reduced_mode;
	assign smp.party_active  = sample.party_active;

	assign sample.ready = in_ready;
	assign accept       = sample.valid && in_ready;

	hpc_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.write_en   (write_en),
		.reg_index  (reg_index),
		.write_data (write_data),
		.cfg        (cfg)
	);

	hpc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (in_ready),
		.status   (status),
		.ctrl     (ctrl)
	);

	hpc_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.accept             (accept),
		.sample             (smp),
		.cfg                (cfg),
		.ctrl               (ctrl),
		.status             (status),
		.res_valid          (result.valid),
		.res_ready          (result.ready),
		.res_flow_setpoint  (result.flow_setpoint),
		.res_valve_position (result.valve_position),
		.res_pump_on        (result.pump_on)
	);
endmodule

// File: rtl/hpc_cfg.sv
// Configuration register bank with reset values of the controller.
// Depends on hpc_pkg for the register map and cfg_t.
module hpc_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           write_en,
	input  logic [hpc_pkg::CFG_IDX_W-1:0]  reg_index,
	input  logic [hpc_pkg::CFG_DATA_W-1:0] write_data,
	output hpc_pkg::cfg_t                  cfg
);
	import hpc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slope   <= 10'd256;
			cfg_q.offset  <= 10'sd0;
			cfg_q.setback <= 9'd160;
			cfg_q.fmin    <= 11'd320;
			cfg_q.fmax    <= 11'd1200;
			cfg_q.start   <= 11'sd272;
			cfg_q.kp      <= 16'd512;
			cfg_q.ki      <= 16'd16;
		end else if (write_en) begin
			case (reg_idx_t'(reg_index))
				REG_SLOPE:   cfg_q.slope   <= write_data[9:0];
				REG_OFFSET:  cfg_q.offset  <= $signed(write_data[9:0]);
				REG_SETBACK: cfg_q.setback <= write_data[8:0];
				REG_FMIN:    cfg_q.fmin    <= write_data[10:0];
				REG_FMAX:    cfg_q.fmax    <= write_data[10:0];
				REG_START:   cfg_q.start   <= $signed(write_data[10:0]);
				REG_KP:      cfg_q.kp      <= write_data;
				REG_KI:      cfg_q.ki      <= write_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// File: rtl/hpc_seq.sv
// Microcode sequencer: program ROM, step counter and jump logic.
// Depends on hpc_pkg for the control word and status structs.
module hpc_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hpc_pkg::dp_status_t status,
	output hpc_pkg::ctrl_t      ctrl
);
	import hpc_pkg::*;

	localparam int unsigned N_STEPS = 11;

	function automatic cw_t mk(mul_sel_t m, alu_op_t op, jump_cond_t jc,
	                           logic [PC_W-1:0] tgt, logic lst);
		cw_t w;
		w.mul_sel     = m;
		w.alu_op      = op;
		w.jump_cond   = jc;
		w.jump_target = tgt;
		w.last        = lst;
		return w;
	endfunction

	localparam cw_t ROM [N_STEPS] = '{
		mk(MUL_CURVE, OP_NOP,      JC_NONE,       4'd0, 1'b0), // 0 diff * slope
		mk(MUL_NONE,  OP_CURVE,    JC_NO_SETBACK, 4'd3, 1'b0), // 1 curve, skip setback
		mk(MUL_NONE,  OP_SETBACK,  JC_NONE,       4'd0, 1'b0), // 2
		mk(MUL_NONE,  OP_CLAMP_LO, JC_NONE,       4'd0, 1'b0), // 3
		mk(MUL_NONE,  OP_CLAMP_HI, JC_NONE,       4'd0, 1'b0), // 4
		mk(MUL_NONE,  OP_ERR,      JC_NONE,       4'd0, 1'b0), // 5 setpoint, error
		mk(MUL_Q0E,   OP_NOP,      JC_NONE,       4'd0, 1'b0), // 6
		mk(MUL_KPP,   OP_SAVE,     JC_NONE,       4'd0, 1'b0), // 7
		mk(MUL_NONE,  OP_DIFF,     JC_NONE,       4'd0, 1'b0), // 8
		mk(MUL_NONE,  OP_SCALE,    JC_NONE,       4'd0, 1'b0), // 9
		mk(MUL_NONE,  OP_SAT,      JC_NONE,       4'd0, 1'b1)  // 10 result out
	};

	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	cw_t             cw;
	logic            run;
	logic            jump;

	assign cw  = ROM[pc_q];
	// hold the final step until the result register is free
	assign run = busy_q && !(cw.last && !status.out_free);

	always_comb begin
		case (cw.jump_cond)
			JC_NONE:       jump = 1'b0;
			JC_NO_SETBACK: jump = !status.setback_en;
			default:       jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
		end else if (!busy_q) begin
			if (in_valid) begin
				busy_q <= 1'b1;
				pc_q   <= '0;
			end
		end else if (run) begin
			if (cw.last) begin
				busy_q <= 1'b0;
			end else if (jump) begin
				pc_q <= cw.jump_target;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

	assign in_ready = !busy_q;
	assign ctrl.run = run;
	assign ctrl.cw  = cw;
endmodule

// File: rtl/hpc_dp.sv
// Datapath: sample latch, shared multiplier, accumulator ALU, controller
// state and the result register. Driven by control words from hpc_seq.
module hpc_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  hpc_pkg::sample_t    sample,
	input  hpc_pkg::cfg_t       cfg,
	input  hpc_pkg::ctrl_t      ctrl,
	output hpc_pkg::dp_status_t status,
	output logic                res_valid,
	input  logic                res_ready,
	output logic [10:0]         res_flow_setpoint,
	output logic [14:0]         res_valve_position,
	output logic                res_pump_on
);
	import hpc_pkg::*;

	sample_t            smp_q;
	logic signed [31:0] prod_q;
	logic signed [31:0] acc_q;
	logic signed [31:0] tmp_q;
	logic        [10:0] sp_q;
	logic signed [12:0] e_q;
	logic signed [12:0] prev_error_q;
	logic        [14:0] valve_acc_q;
	logic               pump_q;
	logic               valid_q;
	logic        [10:0] out_sp_q;
	logic        [14:0] out_valve_q;
	logic               out_pump_q;

	logic signed [12:0] diff;
	logic signed [17:0] mul_a;
	logic signed [13:0] mul_b;
	logic signed [31:0] mul_p;
	logic signed [31:0] acc_d;
	logic signed [31:0] fmin_s;
	logic signed [31:0] fmax_s;
	logic        [14:0] valve_sat;
	logic signed [12:0] start_s;
	logic signed [12:0] avg_s;
	logic signed [11:0] outside_s;
	logic               pump_d;
	logic               do_op;

	assign diff  = $signed({3'b000, smp_q.room_setpoint})
	             - {{2{smp_q.outside_temp[10]}}, smp_q.outside_temp};
	assign fmin_s = $signed({21'd0, cfg.fmin});
	assign fmax_s = $signed({21'd0, cfg.fmax});

	always_comb begin
		case (ctrl.cw.mul_sel)
			MUL_CURVE: begin
				mul_a = $signed({8'd0, cfg.slope});
				mul_b = {diff[12], diff};
			end
			MUL_Q0E: begin
				mul_a = $signed({1'b0, {1'b0, cfg.kp} + {1'b0, cfg.ki}});
				mul_b = {e_q[12], e_q};
			end
			MUL_KPP: begin
				mul_a = $signed({2'b00, cfg.kp});
				mul_b = {prev_error_q[12], prev_error_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = 32'(mul_a) * 32'(mul_b);

	// saturate the new valve value to its travel
	always_comb begin
		if (acc_q < VALVE_MIN) begin
			valve_sat = VALVE_MIN[14:0];
		end else if (acc_q > VALVE_MAX) begin
			valve_sat = VALVE_MAX[14:0];
		end else begin
			valve_sat = acc_q[14:0];
		end
	end

	// pump with hysteresis around the start threshold, frost switch-on within the band
	assign start_s   = {{2{cfg.start[10]}}, cfg.start};
	assign avg_s     = {{2{smp_q.outside_avg[10]}}, smp_q.outside_avg};
	assign outside_s = {smp_q.outside_temp[10], smp_q.outside_temp};
	always_comb begin
		if (avg_s < start_s && sp_q > PUMP_SP_MIN) begin
			pump_d = 1'b1;
		end else if (avg_s > start_s + PUMP_HYST) begin
			pump_d = 1'b0;
		end else if (outside_s < FROST_THRESHOLD) begin
			pump_d = 1'b1;
		end else begin
			pump_d = pump_q;
		end
	end

	always_comb begin
		acc_d = acc_q;
		case (ctrl.cw.alu_op)
			OP_CURVE:    acc_d = (prod_q >>> 8) + $signed({22'd0, smp_q.room_setpoint})
			                   + $signed({{22{cfg.offset[9]}}, cfg.offset});
			OP_SETBACK:  acc_d = acc_q - $signed({23'd0, cfg.setback});
			OP_CLAMP_LO: acc_d = (acc_q < fmin_s) ? fmin_s : acc_q;
			OP_CLAMP_HI: acc_d = (acc_q > fmax_s) ? fmax_s : acc_q;
			OP_DIFF:     acc_d = tmp_q - prod_q;
			OP_SCALE:    acc_d = (acc_q >>> 4) + $signed({17'd0, valve_acc_q});
			default:     acc_d = acc_q;
		endcase
	end

	assign do_op = ctrl.run;

	always_ff @(posedge clk) begin
		if (accept) begin
			smp_q <= sample;
		end
		if (do_op) begin
			if (ctrl.cw.mul_sel != MUL_NONE) begin
				prod_q <= mul_p;
			end
			acc_q <= acc_d;
			if (ctrl.cw.alu_op == OP_SAVE) begin
				tmp_q <= prod_q;
			end
			if (ctrl.cw.alu_op == OP_ERR) begin
				sp_q <= acc_q[10:0];
				e_q  <= $signed({2'b00, acc_q[10:0]}) - $signed({2'b00, smp_q.flow_temp});
			end
			if (ctrl.cw.alu_op == OP_SAT) begin
				out_sp_q    <= sp_q;
				out_valve_q <= valve_sat;
				out_pump_q  <= pump_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_error_q <= '0;
			valve_acc_q  <= '0;
			pump_q       <= 1'b0;
			valid_q      <= 1'b0;
		end else begin
			if (do_op && ctrl.cw.alu_op == OP_SAT) begin
				prev_error_q <= e_q;
				valve_acc_q  <= valve_sat;
				pump_q       <= pump_d;
				valid_q      <= 1'b1;
			end else if (res_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign status.setback_en = smp_q.reduced_mode && !smp_q.party_active;
	assign status.out_free   = !valid_q || res_ready;

	assign res_valid          = valid_q;
	assign res_flow_setpoint  = out_sp_q;
	assign res_valve_position = out_valve_q;
	assign res_pump_on        = out_pump_q;
endmodule
